// ===== sv/qhp_pkg.sv =====
// Shared types and constants for the QUIC header parser.
package qhp_pkg;

	localparam int MAX_CID_LENGTH = 20;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_TUSER_W = 2;

	// Result kinds (carried on m_axis_tuser)
	localparam logic [1:0] KIND_DCID   = 2'd0;
	localparam logic [1:0] KIND_SCID   = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	typedef struct packed {
		logic [7:0]  first_byte;
		logic [31:0] version;
		logic [1:0]  packet_type;
		logic        spin_bit;
		logic        kphase;
		logic [2:0]  pn_length;
		logic [4:0]  dcid_length;
		logic [4:0]  scid_length;
		logic [5:0]  header_length;
	} hdr_t;

	// Everything one packet byte produces: an optional ID byte, then an optional verdict.
	typedef struct packed {
		logic       has_id;
		logic       id_src;
		logic [7:0] id_byte;
		logic       has_verdict;
		logic       accept;
		hdr_t       hdr;
	} rec_t;

endpackage

// ===== sv/qhp_parser.sv =====
// Header parse state machine: one packet byte per cycle in while byte_valid, at most one record out per byte.
module qhp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic [7:0]          data_byte,
	input  logic                end_of_packet,
	input  logic [4:0]          short_dcid_length,
	output logic                rec_push,
	output qhp_pkg::rec_t       rec
);

	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_VERSION = 3'd1;
	localparam logic [2:0] PH_DCIL    = 3'd2;
	localparam logic [2:0] PH_LDCID   = 3'd3;
	localparam logic [2:0] PH_SCIL    = 3'd4;
	localparam logic [2:0] PH_LSCID   = 3'd5;
	localparam logic [2:0] PH_SDCID   = 3'd6;
	localparam logic [2:0] PH_SKIP    = 3'd7;

	localparam logic [7:0] MAX_B = 8'(qhp_pkg::MAX_CID_LENGTH);
	localparam logic [4:0] MAX_L = 5'(qhp_pkg::MAX_CID_LENGTH);

	logic [2:0]  phase_q, phase_d;
	logic [5:0]  byte_pos_q, byte_pos_d;
	logic [7:0]  first_byte_q, first_byte_d;
	logic [31:0] version_q, version_d;
	logic [4:0]  dcid_len_q, dcid_len_d;
	logic [4:0]  scid_len_q, scid_len_d;
	logic [4:0]  id_left_q, id_left_d;

	logic        has_id, id_src, accept, reject, verdict;
	logic [4:0]  id_left_dec;
	qhp_pkg::hdr_t hdr;

	always_comb begin
		phase_d      = phase_q;
		byte_pos_d   = byte_pos_q;
		first_byte_d = first_byte_q;
		version_d    = version_q;
		dcid_len_d   = dcid_len_q;
		scid_len_d   = scid_len_q;
		id_left_d    = id_left_q;
		has_id       = 1'b0;
		id_src       = 1'b0;
		accept       = 1'b0;
		reject       = 1'b0;
		id_left_dec  = id_left_q - 5'd1;

		if (phase_q != PH_SKIP)
			byte_pos_d = byte_pos_q + 6'd1;

		unique case (phase_q)
			PH_FIRST: begin
				byte_pos_d   = 6'd1;
				first_byte_d = data_byte;
				version_d    = '0;
				dcid_len_d   = '0;
				scid_len_d   = '0;
				id_left_d    = '0;
				if (data_byte[7]) begin
					phase_d = PH_VERSION;
				end else if (!data_byte[6] || short_dcid_length > MAX_L) begin
					reject = 1'b1;
				end else begin
					dcid_len_d = short_dcid_length;
					if (short_dcid_length == 5'd0) begin
						accept = 1'b1;
					end else begin
						id_left_d = short_dcid_length;
						phase_d   = PH_SDCID;
					end
				end
			end
			PH_VERSION: begin
				version_d = {version_q[23:0], data_byte};
				if (byte_pos_d == 6'd5) begin
					if (version_d != 32'd0 && !first_byte_q[6])
						reject = 1'b1;
					else
						phase_d = PH_DCIL;
				end
			end
			PH_DCIL, PH_SCIL: begin
				if (data_byte > MAX_B) begin
					reject = 1'b1;
				end else begin
					id_left_d = data_byte[4:0];
					if (phase_q == PH_DCIL) begin
						dcid_len_d = data_byte[4:0];
						phase_d    = (data_byte == 8'd0) ? PH_SCIL : PH_LDCID;
					end else begin
						scid_len_d = data_byte[4:0];
						if (data_byte == 8'd0)
							accept = 1'b1;
						else
							phase_d = PH_LSCID;
					end
				end
			end
			PH_LDCID, PH_LSCID, PH_SDCID: begin
				has_id    = 1'b1;
				id_src    = (phase_q == PH_LSCID);
				id_left_d = id_left_dec;
				if (id_left_dec == 5'd0) begin
					if (phase_q == PH_LDCID)
						phase_d = PH_SCIL;
					else
						accept = 1'b1;
				end
			end
			PH_SKIP: begin
				if (end_of_packet)
					phase_d = PH_FIRST;
			end
			default: phase_d = PH_FIRST;
		endcase

		// early end of packet before the header completed
		if (phase_q != PH_SKIP && !accept && !reject && end_of_packet)
			reject = 1'b1;
		verdict = accept || reject;
		if (verdict)
			phase_d = end_of_packet ? PH_FIRST : PH_SKIP;
	end

	// Header fields come from the updated state; only an accept carries them.
	always_comb begin
		hdr = '0;
		if (accept) begin
			hdr.first_byte    = first_byte_d;
			hdr.dcid_length   = dcid_len_d;
			hdr.header_length = byte_pos_d;
			if (first_byte_d[7]) begin
				hdr.version     = version_d;
				hdr.packet_type = first_byte_d[5:4];
				hdr.scid_length = scid_len_d;
			end else begin
				hdr.spin_bit  = first_byte_d[5];
				hdr.kphase    = first_byte_d[2];
				hdr.pn_length = {1'b0, first_byte_d[1:0]} + 3'd1;
			end
		end
	end

	assign rec.has_id      = has_id;
	assign rec.id_src      = id_src;
	assign rec.id_byte     = data_byte;
	assign rec.has_verdict = verdict;
	assign rec.accept      = accept;
	assign rec.hdr         = hdr;
	assign rec_push        = byte_valid && (has_id || verdict);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			byte_pos_q   <= '0;
			first_byte_q <= '0;
			version_q    <= '0;
			dcid_len_q   <= '0;
			scid_len_q   <= '0;
			id_left_q    <= '0;
		end else if (byte_valid) begin
			phase_q      <= phase_d;
			byte_pos_q   <= byte_pos_d;
			first_byte_q <= first_byte_d;
			version_q    <= version_d;
			dcid_len_q   <= dcid_len_d;
			scid_len_q   <= scid_len_d;
			id_left_q    <= id_left_d;
		end
	end

endmodule

// ===== sv/qhp_out_queue.sv =====
// Result record queue; unrolls each record into one or two output words.
module qhp_out_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rec_push,
	input  qhp_pkg::rec_t                     rec,
	output logic                              full,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [qhp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [qhp_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
	output logic                              m_axis_tlast
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	qhp_pkg::rec_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             id_sent_q;

	qhp_pkg::rec_t head;
	logic          emit_id, word_done, pop;
	qhp_pkg::hdr_t hdr;

	assign head          = entry_q[rd_ptr_q];
	assign full          = (count_q == (PTR_W+1)'(DEPTH));
	assign m_axis_tvalid = (count_q != '0);
	assign emit_id       = head.has_id && !id_sent_q;
	assign word_done     = m_axis_tvalid && m_axis_tready;
	assign pop           = word_done && !(emit_id && head.has_verdict);

	always_comb begin
		hdr = emit_id ? '0 : head.hdr;
		if (emit_id)
			m_axis_tuser = head.id_src ? qhp_pkg::KIND_SCID : qhp_pkg::KIND_DCID;
		else
			m_axis_tuser = head.accept ? qhp_pkg::KIND_ACCEPT : qhp_pkg::KIND_REJECT;
		m_axis_tlast = !(emit_id && head.has_verdict);
		m_axis_tdata = {1'b0, hdr.header_length, hdr.scid_length, hdr.dcid_length,
			hdr.pn_length, hdr.kphase, hdr.spin_bit, hdr.packet_type,
			hdr.version, hdr.first_byte, (emit_id ? head.id_byte : 8'd0)};
	end

	always_ff @(posedge clk) begin
		if (rec_push)
			entry_q[wr_ptr_q] <= rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			id_sent_q <= 1'b0;
		end else begin
			if (rec_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (rec_push && !pop)
				count_q <= count_q + (PTR_W+1)'(1);
			else if (pop && !rec_push)
				count_q <= count_q - (PTR_W+1)'(1);
			if (pop)
				id_sent_q <= 1'b0;
			else if (word_done)
				id_sent_q <= 1'b1;
		end
	end

endmodule

// ===== sv/quic_header_parser_core.sv =====
// Top level of the QUIC packet header parser.
//
//  port group   dir  tdata (low bit first)                         tuser  tlast
//  s_axis       in   data_byte[7:0]                                -      end_of_packet
//  m_axis       out  id_byte, first_header_byte, version[31:0],    kind   last_of_run
//                    packet_type, spin_bit, kphase, pn_length,
//                    dcid_length, scid_length, header_length, pad
//  cfg          in   cfg_we / cfg_wdata = short_dcid_length
//
// One packet byte is taken per cycle while the queue is not full; its results are
// registered into a 4-record queue. A byte that ends an ID with a verdict yields
// two output words. s_axis_tready drops only while the record queue is full.
// arst_n clears the parse state, the queue and short_dcid_length.
module quic_header_parser_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [qhp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_byte
	input  logic                              s_axis_tlast,  // end_of_packet
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// id_byte, first_header_byte, version, packet_type, spin_bit, kphase,
	// pn_length, dcid_length, scid_length, header_length, zero pad
	output logic [qhp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [qhp_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,  // kind
	output logic                              m_axis_tlast,  // last_of_run
	input  logic                              cfg_we,
	input  logic [4:0]                        cfg_wdata      // short_dcid_length
);

	logic [4:0]    short_dcid_length_q;
	logic          full, byte_valid, rec_push;
	qhp_pkg::rec_t rec;

	assign s_axis_tready    = !full;
	assign byte_valid       = s_axis_tvalid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			short_dcid_length_q <= '0;
		else if (cfg_we)
			short_dcid_length_q <= cfg_wdata;
	end

	qhp_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.data_byte         (s_axis_tdata),
		.end_of_packet     (s_axis_tlast),
		.short_dcid_length (short_dcid_length_q),
		.rec_push          (rec_push),
		.rec               (rec)
	);

	qhp_out_queue u_out_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_push      (rec_push),
		.rec           (rec),
		.full          (full),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
